FILE: design/assert_macros.svh
// Assertion helpers shared by the converter's RTL files.
// Each macro takes a label, the clock, the active-low reset, the condition,
// the consequence and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rgbyuv_pkg.sv
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Types, constants and arithmetic helpers for the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbyuv_pkg;

  // Width of the image width register.
  localparam int unsigned CFG_WIDTH_W = 13;
  // Image width after reset.
  localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 13'd640;

  // Width of the scaled numerators (all lie in 16000..239945).
  localparam int unsigned NUM_W = 18;

  // Reciprocal of 1000 scaled by 2**28, rounded up; exact for all numerators here.
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

  // Chroma kind codes.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CB   = 2'd1;
  localparam logic [1:0] KIND_CR   = 2'd2;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
    logic [1:0] chroma_kind;
  } yuv_out_t;

  // Luma numerator: 16000 + 257R + 504G + 98B.
  function automatic logic [NUM_W-1:0] luma_num(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    luma_num = 18'd16000 + NUM_W'(r) * 18'd257 + NUM_W'(g) * 18'd504
             + NUM_W'(b) * 18'd98;
  endfunction

  // Cb numerator: 128000 - 148R - 291G + 439B. The true value is never negative
  // and fits in NUM_W bits, so wrapping arithmetic gives the exact result.
  function automatic logic [NUM_W-1:0] cb_num(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    cb_num = 18'd128000 + NUM_W'(b) * 18'd439 - NUM_W'(r) * 18'd148
           - NUM_W'(g) * 18'd291;
  endfunction

  // Cr numerator: 128000 + 439R - 368G - 71B, computed the same way.
  function automatic logic [NUM_W-1:0] cr_num(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    cr_num = 18'd128000 + NUM_W'(r) * 18'd439 - NUM_W'(g) * 18'd368
           - NUM_W'(b) * 18'd71;
  endfunction

  // Floor of n / 1000 by reciprocal multiplication; the quotient is below 256.
  function automatic logic [7:0] div1000(input logic [NUM_W-1:0] n);
    logic [NUM_W+RECIP_W-1:0] prod;
    prod = (NUM_W+RECIP_W)'(n) * (NUM_W+RECIP_W)'(RECIP_1000);
    div1000 = prod[RECIP_SHIFT +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: design/rgbyuv_raster.sv
// ----------------------------------------------------------------------------
// rgbyuv_raster
// Raster position tracking: image width register, column counter and row
// parity, and the chroma kind of the pixel being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgbyuv_raster
  import rgbyuv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_WIDTH_W-1:0] cfg_wr_data,
  input  wire logic                   pix_accept,
  input  wire logic                   frame_start,
  output logic [1:0]                  chroma_kind
);

  // Column counter width and the width used for the wrap compare.
  localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WIDTH);

  logic [CFG_WIDTH_W-1:0] image_width_r;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic                   row_odd_r, row_odd_nxt;
  logic [COL_W-1:0]       col_eff;
  logic                   row_eff;
  logic [CMP_W-1:0]       width_use;
  logic [CMP_W-1:0]       col_plus1;

  // A frame start pixel is taken as column 0 of row 0.
  assign col_eff = frame_start ? '0 : col_r;
  assign row_eff = frame_start ? 1'b0 : row_odd_r;

  // Chroma is sampled in even columns: Cb on even rows, Cr on odd rows.
  always_comb begin
    if (col_eff[0]) begin
      chroma_kind = KIND_NONE;
    end else if (row_eff) begin
      chroma_kind = KIND_CR;
    end else begin
      chroma_kind = KIND_CB;
    end
  end

  // Width in use: zero counts as one, and it is capped at the maximum.
  always_comb begin
    width_use = CMP_W'(image_width_r);
    if (image_width_r == '0) begin
      width_use = CMP_W'(1);
    end
    if (width_use > MAX_CMP) begin
      width_use = MAX_CMP;
    end
  end

  // Advance the column; wrap and toggle the row parity at the end of a row.
  assign col_plus1 = CMP_W'(col_eff) + CMP_W'(1);

  always_comb begin
    if (col_plus1 >= width_use) begin
      col_nxt     = '0;
      row_odd_nxt = ~row_eff;
    end else begin
      col_nxt     = col_plus1[COL_W-1:0];
      row_odd_nxt = row_eff;
    end
  end

  // Configuration register and raster position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
      col_r         <= '0;
      row_odd_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        image_width_r <= cfg_wr_data;
      end
      if (pix_accept) begin
        col_r     <= col_nxt;
        row_odd_r <= row_odd_nxt;
      end
    end
  end

  // The column never reaches the maximum width.
  `ASSERT_IMPLIES(a_col_in_range, clk, rst_n, 1'b1, CMP_W'(col_r) < MAX_CMP,
                  "column counter beyond maximum width")

  // A frame start pixel is always a Cb sample.
  `ASSERT_IMPLIES(a_frame_start_cb, clk, rst_n, pix_accept && frame_start,
                  chroma_kind == KIND_CB, "frame start pixel is not a Cb sample")

  // The column only moves when a pixel is taken.
  `ASSERT_NEXT(a_col_hold, clk, rst_n, !pix_accept, $stable(col_r),
               "column counter moved without a pixel")

endmodule

`default_nettype wire

FILE: design/rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB24 to BT.601 studio-range YCbCr 4:2:0 pixel converter.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while in_stall is low and returns one
// item per pixel: the pixel's luma, plus a Cb (even rows) or Cr (odd rows)
// sample for pixels in even columns. Each pixel passes through the first
// register, which holds the scaled numerators, then the second, which holds
// the quotients after the reciprocal multiply by 1/1000 and drives the
// output. With out_stall low, a new pixel can follow in every cycle.
// in_stall rises only when both stages are full and the output is stalled.
// image_width is to be written through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block itself does not enforce this. frame_start on
// a pixel restarts the raster at column 0, row 0.
`default_nettype none

`include "assert_macros.svh"

module rgb_to_yuv420_converter
  import rgbyuv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Pixel input.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pixel_in_t              in_item,
  // Result output.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output yuv_out_t                    out_item,
  // Image width register.
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_WIDTH_W-1:0] cfg_wr_data
);

  logic             in_accept;
  logic             out_advance;
  logic [1:0]       kind;
  logic [NUM_W-1:0] luma_num_nxt, chroma_num_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic [NUM_W-1:0] s1_luma_num_r, s1_chroma_num_r;
  logic [1:0]       s1_kind_r;

  logic             out_valid_r, out_valid_nxt;
  yuv_out_t         out_item_r, out_item_nxt;

  // Pipeline flow: the output stage moves when empty or taken.
  assign out_advance = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !out_advance;
  assign in_accept   = in_valid && !in_stall;

  // Raster position and chroma kind of the incoming pixel.
  rgbyuv_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pix_accept  (in_accept),
    .frame_start (in_item.frame_start),
    .chroma_kind (kind)
  );

  // First stage: scaled numerators from constant coefficient products.
  assign luma_num_nxt = luma_num(in_item.red, in_item.green, in_item.blue);

  always_comb begin
    unique case (kind)
      KIND_CR: chroma_num_nxt = cr_num(in_item.red, in_item.green, in_item.blue);
      default: chroma_num_nxt = cb_num(in_item.red, in_item.green, in_item.blue);
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Second stage: divide by 1000 and form the result item.
  always_comb begin
    out_item_nxt.luma        = div1000(s1_luma_num_r);
    out_item_nxt.chroma_kind = s1_kind_r;
    if (s1_kind_r == KIND_NONE) begin
      out_item_nxt.chroma = '0;
    end else begin
      out_item_nxt.chroma = div1000(s1_chroma_num_r);
    end
  end

  assign out_valid_nxt = out_advance ? s1_valid_r : out_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_luma_num_r   <= luma_num_nxt;
      s1_chroma_num_r <= chroma_num_nxt;
      s1_kind_r       <= kind;
    end
    if (out_advance && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Input is held off only when both stages are occupied.
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r,
                  "input stalled with a free stage")

  // Luma stays inside the studio range.
  `ASSERT_IMPLIES(a_luma_range, clk, rst_n, out_valid_r,
                  out_item_r.luma >= 8'd16 && out_item_r.luma <= 8'd235,
                  "luma out of studio range")

  // Results without a chroma sample carry a zero chroma field, and no
  // undefined kind code ever appears.
  `ASSERT_IMPLIES(a_chroma_kind, clk, rst_n, out_valid_r,
                  (out_item_r.chroma_kind == KIND_NONE && out_item_r.chroma == 8'd0) ||
                  out_item_r.chroma_kind == KIND_CB || out_item_r.chroma_kind == KIND_CR,
                  "bad chroma kind or stray chroma value")

  // A held first-stage item is still there in the next cycle.
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !out_advance, s1_valid_r,
               "first stage item lost while output stalled")

endmodule

`default_nettype wire

FILE: sim/yuv420_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_checker
// Watches the pixel, result and width-register ports of the converter. It
// predicts the luma and chroma item for every accepted pixel from its own
// copy of the raster position and image width, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module yuv420_checker
  import rgbyuv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  pixel_in_t              in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  yuv_out_t               out_item,
  input  logic                   cfg_wr_en,
  input  logic [CFG_WIDTH_W-1:0] cfg_wr_data,
  output int                     fail_count,
  output int                     pending
);

  // Widest row the block supports; larger register values are clamped to it.
  localparam int MAX_COLS = 4096;

  logic [CFG_WIDTH_W-1:0] width_reg;
  int                     col_count;
  bit                     row_odd;
  yuv_out_t               expected_yuv[$];
  int                     errors = 0;

  // Converts one pixel at the current raster position and advances the position.
  function automatic yuv_out_t convert_pixel(input pixel_in_t px);
    int       r;
    int       g;
    int       b;
    int       w;
    yuv_out_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    // A frame start puts the pixel at column 0 of row 0.
    if (px.frame_start) begin
      col_count = 0;
      row_odd = 1'b0;
    end
    // All numerators are positive, so integer division is the floor.
    res.luma = 8'((16000 + 257 * r + 504 * g + 98 * b) / 1000);
    if ((col_count % 2) == 0) begin
      if (!row_odd) begin
        res.chroma = 8'((128000 - 148 * r - 291 * g + 439 * b) / 1000);
        res.chroma_kind = KIND_CB;
      end else begin
        res.chroma = 8'((128000 + 439 * r - 368 * g - 71 * b) / 1000);
        res.chroma_kind = KIND_CR;
      end
    end else begin
      res.chroma = 8'd0;
      res.chroma_kind = KIND_NONE;
    end
    // A zero width acts as one; anything past the maximum acts as the maximum.
    w = int'(width_reg);
    if (w == 0) begin
      w = 1;
    end
    if (w > MAX_COLS) begin
      w = MAX_COLS;
    end
    // The column wraps once it reaches or passes the width, even mid-row.
    if (col_count + 1 >= w) begin
      col_count = 0;
      row_odd = !row_odd;
    end else begin
      col_count = col_count + 1;
    end
    return res;
  endfunction

  // Track register writes, check results, then queue predictions for new pixels.
  always @(posedge clk) begin : watch
    yuv_out_t want;
    bit       bad;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      col_count = 0;
      row_odd = 1'b0;
      expected_yuv.delete();
    end else begin
      if (cfg_wr_en) begin
        width_reg = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_yuv.size() == 0) begin
          errors++;
          $display("%0t: result with no pixel pending: luma %0d chroma %0d kind %0d",
                   $time, out_item.luma, out_item.chroma, out_item.chroma_kind);
        end else begin
          want = expected_yuv.pop_front();
          bad = 1'b0;
          if (out_item.luma !== want.luma) begin
            bad = 1'b1;
            $display("%0t: luma mismatch: expected %0d, got %0d",
                     $time, want.luma, out_item.luma);
          end
          if (out_item.chroma !== want.chroma) begin
            bad = 1'b1;
            $display("%0t: chroma mismatch: expected %0d, got %0d",
                     $time, want.chroma, out_item.chroma);
          end
          if (out_item.chroma_kind !== want.chroma_kind) begin
            bad = 1'b1;
            $display("%0t: chroma_kind mismatch: expected %0d, got %0d",
                     $time, want.chroma_kind, out_item.chroma_kind);
          end
          if (bad) begin
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_yuv.insert(expected_yuv.size(), convert_pixel(in_item));
      end
    end
    fail_count <= errors;
    pending <= expected_yuv.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RGB to YCbCr 4:2:0 converter. A short directed
// sequence covers the color extremes, both chroma rows, frame starts and the
// width corner cases; random phases then stream pixels at many image widths
// with random gaps and output stalls, one long output hold and idle pauses.
// The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module tb;
  import rgbyuv_pkg::*;

  localparam int NUM_PHASES  = 15;
  localparam int PHASE_ITEMS = 102;
  localparam int HOLD_CYCLES = 80;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  pixel_in_t              in_item;
  logic                   out_valid;
  logic                   out_stall;
  yuv_out_t               out_item;
  logic                   cfg_wr_en;
  logic [CFG_WIDTH_W-1:0] cfg_wr_data;
  int                     fail_count;
  int                     pending;

  // Gap and stall ceilings for the current phase; zero means no idling.
  int gap_limit    = 0;
  int stall_limit  = 0;
  bit hold_request = 1'b0;

  rgb_to_yuv420_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  yuv420_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one pixel after a random gap and returns at the edge that takes it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic fs);
    int        gap;
    pixel_in_t px;
    gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    px.red = r;
    px.green = g;
    px.blue = b;
    px.frame_start = fs;
    in_item <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering pixels and waits until every predicted item has come out.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the image width once the block has drained.
  task automatic write_width(input logic [CFG_WIDTH_W-1:0] w);
    settle_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Color level biased toward the ends of the range.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: a random stall before each item, or one long hold on request.
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        n = (stall_limit == 0) ? 0 : $urandom_range(0, stall_limit);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Pixel side: reset, directed sequence, random phases, then the verdict.
  initial begin : stimulus
    logic [CFG_WIDTH_W-1:0] w;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width of 640: a few pixels along the first row.
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);

    // Width 2 alternates Cb and Cr rows and hits both chroma extremes.
    write_width(13'd2);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    // A frame start in the middle of a row.
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b1);

    // A zero width acts as one: every pixel starts a new row.
    write_width(13'd0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(8'd50, 8'd100, 8'd200, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);

    // Oversized width, then a narrower one while the column lies beyond it.
    write_width(13'd8191);
    send_pixel(8'd17, 8'd34, 8'd51, 1'b1);
    send_pixel(8'd68, 8'd85, 8'd102, 1'b0);
    send_pixel(8'd119, 8'd136, 8'd153, 1'b0);
    send_pixel(8'd170, 8'd187, 8'd204, 1'b0);
    send_pixel(8'd221, 8'd238, 8'd255, 1'b0);
    write_width(13'd3);
    send_pixel(8'd90, 8'd60, 8'd30, 1'b0);
    send_pixel(8'd30, 8'd60, 8'd90, 1'b0);

    write_width(13'd1);
    send_pixel(8'd255, 8'd128, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd128, 8'd255, 1'b0);

    // Random phases, each at its own width and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        w = 13'd4096;
      end else if (p == 1) begin
        w = 13'd8191;
      end else begin
        case ($urandom_range(0, 9))
          0: w = 13'($urandom_range(0, 8191));
          1: w = 13'($urandom_range(13, 700));
          default: w = 13'($urandom_range(1, 12));
        endcase
      end
      write_width(w);
      gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 10;
      stall_limit = ($urandom_range(0, 2) == 0) ? 0 : 10;
      // One phase streams back to back into a long output hold.
      if (p == 3) begin
        gap_limit = 0;
        hold_request = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Sometimes drain halfway and change the width mid-row.
        if (i == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0) begin
          write_width(13'($urandom_range(1, 9)));
        end
        send_pixel(pick_level(), pick_level(), pick_level(),
                   (i == 0) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 63) == 0));
      end
    end

    // Drain, leave room for any stray item, then report.
    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Safety net for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
